// ===== src/rpbm_pkg.sv =====
package rpbm_pkg;

	localparam int CH_W = 8;
	localparam int PROD_W = 2 * CH_W;
	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_DARKEN   = 3'd1,
		MODE_MULTIPLY = 3'd2,
		MODE_LIGHTEN  = 3'd3,
		MODE_SCREEN   = 3'd4,
		MODE_DODGE    = 3'd5,
		MODE_SUBTRACT = 3'd6,
		MODE_OPAQUE   = 3'd7
	} blend_mode_t;

	// floor(p / 255) for p <= 255*255: (p + (p >> 8) + 1) >> 8
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] sum;
		sum = {1'b0, p} + {{(CH_W+1){1'b0}}, p[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
		return sum[PROD_W-1:CH_W];
	endfunction

endpackage

// ===== src/rpbm_blend.sv =====
module rpbm_blend (
	input  logic                    clk,
	input  logic                    en,
	input  logic [rpbm_pkg::CH_W-1:0] s,
	input  logic [rpbm_pkg::CH_W-1:0] d,
	input  logic [rpbm_pkg::CH_W-1:0] a,
	input  rpbm_pkg::blend_mode_t   mode,
	output logic [rpbm_pkg::CH_W-1:0] x,
	output logic [rpbm_pkg::CH_W-1:0] d_out,
	output logic [rpbm_pkg::CH_W-1:0] a_out
);
	import rpbm_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic [CH_W-1:0]   s_s1, d_s1, a_s1;
	blend_mode_t       mode_s1;
	logic [CH_W-1:0]   x_s2, d_s2, a_s2;

	logic [CH_W-1:0]   prod;
	logic [CH_W:0]     sum;
	logic [CH_W:0]     scr;
	logic [CH_W-1:0]   x_nxt;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= s * d;
			s_s1    <= s;
			d_s1    <= d;
			a_s1    <= a;
			mode_s1 <= mode;
		end
	end

	assign prod = div255(prod_s1);
	assign sum  = {1'b0, s_s1} + {1'b0, d_s1};
	// prod never exceeds min(s, d), so no underflow
	assign scr  = sum - {1'b0, prod};

	always_comb begin
		case (mode_s1)
			MODE_NORMAL:   x_nxt = s_s1;
			MODE_DARKEN:   x_nxt = (s_s1 < d_s1) ? s_s1 : d_s1;
			MODE_MULTIPLY: x_nxt = prod;
			MODE_LIGHTEN:  x_nxt = (s_s1 > d_s1) ? s_s1 : d_s1;
			MODE_SCREEN:   x_nxt = scr[CH_W] ? CH_MAX : scr[CH_W-1:0];
			MODE_DODGE:    x_nxt = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
			MODE_SUBTRACT: x_nxt = (s_s1 >= d_s1) ? (s_s1 - d_s1) : (d_s1 - s_s1);
			MODE_OPAQUE:   x_nxt = {1'b0, s_s1[CH_W-1:1]} + {1'b0, d_s1[CH_W-1:1]};
			default:       x_nxt = s_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_nxt;
			d_s2 <= d_s1;
			a_s2 <= a_s1;
		end
	end

	assign x     = x_s2;
	assign d_out = d_s2;
	assign a_out = a_s2;

endmodule

// ===== src/rpbm_mix.sv =====
module rpbm_mix (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rpbm_pkg::CH_W-1:0] x,
	input  logic [rpbm_pkg::CH_W-1:0] d,
	input  logic [rpbm_pkg::CH_W-1:0] a,
	output logic [rpbm_pkg::CH_W-1:0] res
);
	import rpbm_pkg::*;

	logic [PROD_W-1:0] xa_s3, da_s3;
	logic [CH_W-1:0]   res_s4;
	logic [PROD_W-1:0] mix;

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s3 <= x * a;
			da_s3 <= d * (CH_MAX - a);
		end
	end

	// x*a + d*(255-a) stays within 255*255
	assign mix = xa_s3 + da_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= div255(mix);
		end
	end

	assign res = res_s4;

endmodule

// ===== src/rgba_pixel_blend_modes.sv =====
// Each input transfer passes through four registered stages; stage 4 is the output register.
// Throughput: one pixel per cycle unless a finished result is stalled; stages 1 and 3 hold the 8x8 multipliers,
// stages 2 and 4 the divide-by-255 and the mode select / final mix.
// Reset (arst_n low, asynchronous) clears the stage valid bits only;
// the data registers are not reset.
module rgba_pixel_blend_modes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] source_pixel,
	input  logic [23:0] dest_pixel,
	input  logic [2:0]  mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] blended_pixel
);
	import rpbm_pkg::*;

	localparam int NCH = 3;

	// Stage valid bits travel with the data through all four stages
	logic v_s1, v_s2, v_s3, v_s4;
	logic en;

	logic [CH_W-1:0] alpha;
	blend_mode_t     mode_in;
	logic [CH_W-1:0] ch_s   [NCH];
	logic [CH_W-1:0] ch_d   [NCH];
	logic [CH_W-1:0] ch_x   [NCH];
	logic [CH_W-1:0] ch_d2  [NCH];
	logic [CH_W-1:0] ch_a2  [NCH];
	logic [CH_W-1:0] ch_res [NCH];

	// Whole pipe advances unless a finished result is held back downstream;
	// bubbles ahead of a stalled output are not squeezed out.
	assign en       = !(v_s4 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign alpha   = source_pixel[31:24];
	assign mode_in = blend_mode_t'(mode);

	// Channel 0 red, 1 green, 2 blue
	for (genvar i = 0; i < NCH; i++) begin : g_ch
		assign ch_s[i] = source_pixel[i*CH_W +: CH_W];
		assign ch_d[i] = dest_pixel[i*CH_W +: CH_W];

		rpbm_blend u_blend (
			.clk   (clk),
			.en    (en),
			.s     (ch_s[i]),
			.d     (ch_d[i]),
			.a     (alpha),
			.mode  (mode_in),
			.x     (ch_x[i]),
			.d_out (ch_d2[i]),
			.a_out (ch_a2[i])
		);

		rpbm_mix u_mix (
			.clk (clk),
			.en  (en),
			.x   (ch_x[i]),
			.d   (ch_d2[i]),
			.a   (ch_a2[i]),
			.res (ch_res[i])
		);
	end

	assign out_valid     = v_s4;
	// Output alpha is always opaque
	assign blended_pixel = {CH_MAX, ch_res[2], ch_res[1], ch_res[0]};

endmodule

// ===== src/rpbm_checker.sv =====
module rpbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] blended_pixel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blended_pixel))
		else $error("stalled result changed or dropped");

	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> blended_pixel[31:24] == 8'hFF)
		else $error("output alpha not opaque");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

endmodule

bind rgba_pixel_blend_modes rpbm_checker u_rpbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.blended_pixel (blended_pixel)
);
